@@ rtl/dnsarp_pkg.sv @@
`default_nettype none

package dnsarp_pkg;

   localparam int MAX_PACKET = 512;
   localparam int POS_W = $clog2(MAX_PACKET + 1);

   localparam int HEADER_LEN = 12;
   localparam int SKIP_LEN = 16;
   localparam int ADDR_BYTES = 4;

   localparam logic [15:0] QUERY_ID_RESET = 16'h4334;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_INDEX_QUERY_ID = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_MISMATCH = 2'd2,
      STATUS_TRUNC    = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] address;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/dnsarp_if.sv @@
`default_nettype none

interface dnsarp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsarp_rsp_if import dnsarp_pkg::*;;
   logic        valid;
   logic        ready;
   status_type  status;
   logic [31:0] address;

   modport source (output valid, output status, output address, input ready);
   modport sink (input valid, input status, input address, output ready);
endinterface

`default_nettype wire

@@ rtl/dnsarp_csr.sv @@
`default_nettype none

module dnsarp_csr import dnsarp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output logic [15:0]                query_id
);

   logic [15:0] query_id_ff;
   logic [15:0] query_id_in;
   logic        hit_query_id;

   assign hit_query_id = (csr_paddr[2] == CSR_INDEX_QUERY_ID);
   assign csr_pready = 1'b1;

   always_comb begin
      query_id_in = query_id_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit_query_id) begin
         query_id_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_id_ff <= QUERY_ID_RESET;
      end else begin
         query_id_ff <= query_id_in;
      end
   end

   assign csr_prdata = hit_query_id ? {16'd0, query_id_ff} : 32'd0;
   assign query_id = query_id_ff;

endmodule

`default_nettype wire

@@ rtl/dnsarp_parser.sv @@
`default_nettype none

module dnsarp_parser import dnsarp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        take,
   input  wire logic [7:0]  data_byte,
   input  wire logic        last_byte,
   input  wire logic [15:0] query_id,
   output logic             res_valid,
   output result_type       result
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME_LEN,
      PH_LABEL,
      PH_SKIP,
      PH_ADDR,
      PH_DONE
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [6:0]        label_ff, label_in;
   logic [4:0]        skip_ff, skip_in;
   logic [2:0]        seen_ff, seen_in;
   logic [31:0]       shift_ff, shift_in;
   logic              mismatch_ff, mismatch_in;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      label_in    = label_ff;
      skip_in     = skip_ff;
      seen_in     = seen_ff;
      shift_in    = shift_ff;
      mismatch_in = mismatch_ff;
      res_valid   = 1'b0;
      result      = '{status: STATUS_OK, address: 32'd0};

      if (take && (pos_ff < POS_W'(MAX_PACKET))) begin
         pos_in = pos_ff + POS_W'(1);
         case (phase_ff)
            PH_HEADER: begin
               if ((pos_ff == POS_W'(0)) && (data_byte != query_id[15:8])) begin
                  mismatch_in = 1'b1;
               end
               if ((pos_ff == POS_W'(1)) && (data_byte != query_id[7:0])) begin
                  mismatch_in = 1'b1;
               end
               if (pos_ff == POS_W'(HEADER_LEN - 1)) begin
                  phase_in = PH_NAME_LEN;
               end
            end
            PH_NAME_LEN: begin
               if ((data_byte == 8'd0) || data_byte[7]) begin
                  skip_in  = 5'(SKIP_LEN);
                  phase_in = PH_SKIP;
               end else begin
                  label_in = data_byte[6:0];
                  phase_in = PH_LABEL;
               end
            end
            PH_LABEL: begin
               label_in = label_ff - 7'd1;
               if (label_in == 7'd0) begin
                  phase_in = PH_NAME_LEN;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 5'd1;
               if (skip_in == 5'd0) begin
                  phase_in = PH_ADDR;
               end
            end
            PH_ADDR: begin
               shift_in = {shift_ff[23:0], data_byte};
               seen_in  = seen_ff + 3'd1;
               if (seen_in >= 3'(ADDR_BYTES)) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      if (take && last_byte) begin
         res_valid = 1'b1;
         if (pos_in < POS_W'(HEADER_LEN)) begin
            result.status = STATUS_SHORT;
         end else if (mismatch_in) begin
            result.status = STATUS_MISMATCH;
         end else if (seen_in < 3'(ADDR_BYTES)) begin
            result.status = STATUS_TRUNC;
         end else begin
            result.status  = STATUS_OK;
            result.address = shift_in;
         end
         phase_in    = PH_HEADER;
         pos_in      = '0;
         label_in    = '0;
         skip_in     = '0;
         seen_in     = '0;
         shift_in    = '0;
         mismatch_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         label_ff    <= '0;
         skip_ff     <= '0;
         seen_ff     <= '0;
         shift_ff    <= '0;
         mismatch_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         label_ff    <= label_in;
         skip_ff     <= skip_in;
         seen_ff     <= seen_in;
         shift_ff    <= shift_in;
         mismatch_ff <= mismatch_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/dnsarp_outbuf.sv @@
`default_nettype none

module dnsarp_outbuf import dnsarp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        res_valid,
   input  wire result_type  result,
   output logic             in_ready,
   output logic             out_valid,
   input  wire logic        out_ready,
   output result_type       out_result
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (res_valid) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_ready   = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

`default_nettype wire

@@ rtl/dns_a_record_response_parser.sv @@
// DNS A-record response parser.
// The req_chan channel carries the packet one byte per item, with last_byte set
// on the final byte. The header id is checked against query_id, the question
// name is walked, and the first answer address is gathered.
// One item on rsp_chan follows each item that has last_byte set; it carries
// the status and, when the status is ok, the IPv4 address.
// The parse state updates at the edge that accepts a byte, and the result is
// registered in the output register, or in the skid entry when that is held.
// While ready is high a byte can be accepted in every cycle; one item per cycle.
// Behind the result register sits one skid entry, so req_chan stays ready
// while a single result waits; it drops ready only when two results are held.
// query_id is written over the APB-style csr_ port at byte address 0 and
// resets to 0x4334. Reset clears the parser, which then expects a new packet.
// Bytes beyond MAX_PACKET are not parsed, but their last_byte flag still counts.
`default_nettype none

module dns_a_record_response_parser import dnsarp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   dnsarp_req_if.sink                 req_chan,
   dnsarp_rsp_if.source               rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [15:0] query_id;
   logic        take;
   logic        in_ready;
   logic        res_valid;
   result_type  result;
   result_type  out_result;

   dnsarp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .query_id    (query_id)
   );

   assign req_chan.ready = in_ready;
   assign take = req_chan.valid && in_ready;

   dnsarp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .query_id  (query_id),
      .res_valid (res_valid),
      .result    (result)
   );

   dnsarp_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .result     (result),
      .in_ready   (in_ready),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_result (out_result)
   );

   assign rsp_chan.status  = out_result.status;
   assign rsp_chan.address = out_result.address;

endmodule

`default_nettype wire

@@ dv/dnsarp_tb_pkg.sv @@
`default_nettype none

package dnsarp_tb_pkg;
   import dnsarp_pkg::*;

   class answer_tracker;
      typedef enum logic [2:0] {
         PH_HEADER, PH_NAME_LEN, PH_LABEL, PH_SKIP, PH_ADDR, PH_DONE
      } phase_type;

      logic [15:0] query_id;
      phase_type   phase;
      logic [9:0]  byte_pos;
      logic [6:0]  label_left;
      logic [4:0]  skip_left;
      logic [2:0]  addr_count;
      logic [31:0] addr_acc;
      bit          id_bad;
      result_type  expected_answers[$];
      int unsigned failures;

      function new();
         query_id = QUERY_ID_RESET;
         failures = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         phase = PH_HEADER;
         byte_pos = '0;
         label_left = '0;
         skip_left = '0;
         addr_count = '0;
         addr_acc = '0;
         id_bad = 1'b0;
      endfunction

      function void note_byte(logic [7:0] d, logic last);
         result_type r;
         if (byte_pos < MAX_PACKET) begin
            case (phase)
               PH_HEADER: begin
                  if (byte_pos == 0 && d != query_id[15:8]) id_bad = 1'b1;
                  if (byte_pos == 1 && d != query_id[7:0]) id_bad = 1'b1;
                  if (byte_pos == HEADER_LEN - 1) phase = PH_NAME_LEN;
               end
               PH_NAME_LEN: begin
                  if (d == 8'd0 || d >= 8'd128) begin
                     skip_left = 5'(SKIP_LEN);
                     phase = PH_SKIP;
                  end else begin
                     label_left = d[6:0];
                     phase = PH_LABEL;
                  end
               end
               PH_LABEL: begin
                  label_left = label_left - 7'd1;
                  if (label_left == 7'd0) phase = PH_NAME_LEN;
               end
               PH_SKIP: begin
                  skip_left = skip_left - 5'd1;
                  if (skip_left == 5'd0) phase = PH_ADDR;
               end
               PH_ADDR: begin
                  addr_acc = {addr_acc[23:0], d};
                  addr_count = addr_count + 3'd1;
                  if (addr_count >= ADDR_BYTES) phase = PH_DONE;
               end
               default: ;
            endcase
            byte_pos = byte_pos + 10'd1;
         end
         if (last) begin
            r.address = '0;
            if (byte_pos < HEADER_LEN) r.status = STATUS_SHORT;
            else if (id_bad) r.status = STATUS_MISMATCH;
            else if (addr_count < ADDR_BYTES) r.status = STATUS_TRUNC;
            else begin
               r.status = STATUS_OK;
               r.address = addr_acc;
            end
            expected_answers.push_back(r);
            clear_packet();
         end
      endfunction

      function void check_answer(status_type s, logic [31:0] a);
         result_type e;
         if (expected_answers.size() == 0) begin
            $error("unexpected answer: status %0d address %h", s, a);
            failures++;
            return;
         end
         e = expected_answers.pop_front();
         if (s !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, s);
            failures++;
         end
         if (a !== e.address) begin
            $error("address: expected %h, actual %h", e.address, a);
            failures++;
         end
      endfunction
   endclass

endpackage

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dnsarp_pkg::*;
   import dnsarp_tb_pkg::*;

   localparam int SETTLE = 4;
   localparam int HOLD_OFF = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_ADDR_W-1:0] QUERY_ID_ADDR = CSR_ADDR_W'(4 * CSR_INDEX_QUERY_ID);

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   dnsarp_req_if req_chan ();
   dnsarp_rsp_if rsp_chan ();

   answer_tracker tracker = new();
   logic [7:0] pkt[$];
   bit calm = 1'b0;
   bit hold_off_request = 1'b0;
   int bytes_sent = 0;
   int idle_cycles = 0;

   dns_a_record_response_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         tracker.note_byte(req_chan.data_byte, req_chan.last_byte);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_answer(rsp_chan.status, rsp_chan.address);
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_psel && csr_penable && csr_pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("dns_a_record_response_parser: mismatch");
      $finish;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 33);
         end
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic last);
      if (!calm) begin
         while ($urandom_range(0, 99) < 33) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= d;
      req_chan.last_byte <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet(input int first);
      for (int i = first; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_query_id(input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= QUERY_ID_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.query_id = value[15:0];
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[15:0] !== tracker.query_id) begin
         $error("query_id: expected %h, actual %h", tracker.query_id, csr_prdata[15:0]);
         tracker.failures++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic void build_response(input logic [15:0] id, input int labels,
                                          input int label_len, input logic [7:0] term,
                                          input logic [31:0] address, input int trailing);
      int len;
      pkt.delete();
      pkt.push_back(id[15:8]);
      pkt.push_back(id[7:0]);
      repeat (HEADER_LEN - 2) pkt.push_back(8'($urandom));
      repeat (labels) begin
         len = (label_len != 0) ? label_len : $urandom_range(1, 8);
         pkt.push_back(8'(len));
         repeat (len) pkt.push_back(8'($urandom));
      end
      pkt.push_back(term);
      repeat (SKIP_LEN) pkt.push_back(8'($urandom));
      for (int i = ADDR_BYTES - 1; i >= 0; i--) pkt.push_back(address[8*i +: 8]);
      repeat (trailing) pkt.push_back(8'($urandom));
   endfunction

   task automatic send_random_packet();
      int kind;
      int n;
      logic [15:0] id;
      logic [7:0] term;
      kind = $urandom_range(0, 99);
      id = tracker.query_id;
      if (kind >= 60 && kind < 70) id = id ^ 16'(1 << $urandom_range(0, 15));
      term = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(128, 255));
      build_response(id, $urandom_range(0, 3), 0, term, $urandom, $urandom_range(0, 4));
      if (kind >= 70 && kind < 80) begin
         n = $urandom_range(1, pkt.size() - 1);
         pkt = pkt[0:n-1];
      end else if (kind >= 80 && kind < 98) begin
         n = (kind < 90) ? $urandom_range(1, HEADER_LEN - 1) : $urandom_range(HEADER_LEN, 60);
         pkt.delete();
         repeat (n) pkt.push_back(8'($urandom));
      end
      send_packet(0);
   endtask

   initial begin
      int first_byte;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.last_byte <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      build_response(QUERY_ID_RESET, 0, 0, 8'h00, 32'hFFFF_FFFF, 0);
      send_packet(0);
      build_response(QUERY_ID_RESET, 2, 0, 8'h80, $urandom, 0);
      send_packet(0);
      pkt = pkt[0:0];
      send_packet(0);
      build_response(QUERY_ID_RESET, 1, 0, 8'h00, $urandom, 0);
      pkt = pkt[0:HEADER_LEN-2];
      send_packet(0);
      build_response(QUERY_ID_RESET, 1, 0, 8'h00, $urandom, 0);
      pkt = pkt[0:HEADER_LEN-1];
      send_packet(0);
      build_response(QUERY_ID_RESET, 1, 0, 8'hFF, $urandom, 0);
      pkt = pkt[0:pkt.size()-2];
      send_packet(0);
      build_response(QUERY_ID_RESET ^ 16'h8000, 1, 0, 8'h00, $urandom, 0);
      send_packet(0);
      build_response(QUERY_ID_RESET ^ 16'h0001, 1, 0, 8'h00, $urandom, 0);
      send_packet(0);
      build_response(QUERY_ID_RESET ^ 16'hFFFF, 1, 0, 8'h00, $urandom, 0);
      pkt = pkt[0:4];
      send_packet(0);
      build_response(QUERY_ID_RESET, 1, 127, 8'hC0, 32'h0000_0000, 0);
      while (pkt.size() < MAX_PACKET + 3) pkt.push_back(8'($urandom));
      send_packet(0);

      drain_results();
      set_query_id(32'h0000_0000);
      build_response(16'h0000, 1, 0, 8'h00, $urandom, 1);
      send_packet(0);
      build_response(16'hFFFF, 1, 0, 8'h00, $urandom, 0);
      send_packet(0);

      drain_results();
      set_query_id(32'hFFFF_FFFF);
      build_response(16'hFFFF, 2, 0, 8'h90, $urandom, 0);
      send_packet(0);

      // The id register changes between the two id bytes of one packet.
      build_response(16'hFF5A, 1, 0, 8'h00, 32'hC0A8_0001, 0);
      send_byte(pkt[0], 1'b0);
      drain_results();
      set_query_id(32'hA5A5_005A);
      send_packet(1);

      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         set_query_id($urandom);
         calm = (phase == 1);
         if (phase == 2) begin
            hold_off_request = 1'b1;
            repeat (6) begin
               pkt.delete();
               pkt.push_back(8'($urandom));
               send_packet(0);
            end
         end
         first_byte = bytes_sent;
         while (bytes_sent - first_byte < 40)
            send_random_packet();
      end
      calm = 1'b0;

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (tracker.failures == 0)
         $display("dns_a_record_response_parser: match");
      else
         $display("dns_a_record_response_parser: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
